// ===== hw/rtl/acked_command_sender_assert.svh =====
// Assertion macros for the RTL of the command sender.
// Each macro builds one labeled concurrent assertion on clk, held off in reset.
`ifndef ACKED_COMMAND_SENDER_ASSERT_SVH
`define ACKED_COMMAND_SENDER_ASSERT_SVH

// Same-cycle implication.
`define ACS_ASSERT_NOW(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
    else $error("acked_command_sender assertion failed");

// Next-cycle implication.
`define ACS_ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error("acked_command_sender assertion failed");

`endif

// ===== hw/rtl/acs_pkg.sv =====
package acs_pkg;

  // Default queue depth; the queue holds one entry less than this.
  localparam int unsigned ACS_QUEUE_DEPTH = 8;

  // Field widths.
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned TRIES_W = 4;
  localparam int unsigned FAIL_W  = 16;
  localparam int unsigned QCNT_W  = 3;
  localparam int unsigned CIDX_W  = 2;

  // Register reset values.
  localparam logic [TICK_W-1:0]  GAP_TICKS_RST   = 16'd100;
  localparam logic [TICK_W-1:0]  ACK_TIMEOUT_RST = 16'd2000;
  localparam logic [TRIES_W-1:0] MAX_TRIES_RST   = 4'd3;

  // Register indexes.
  localparam logic [CIDX_W-1:0] CFG_GAP_TICKS     = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_ACK_TIMEOUT   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MAX_TRIES     = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_LINK_DISABLED = 2'd3;

  // Beat kinds on the input channel.
  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_ENQUEUE = 2'd1,
    MODE_ACK     = 2'd2
  } mode_t;

endpackage

// ===== hw/rtl/acked_command_sender.sv =====
// Stop-and-wait command sender with a ring queue of command codes.
// Input channel (in_valid / in_stall): each beat is a tick, an enqueue of
// in_code, or an acknowledgement naming in_code. Output channel
// (out_valid / out_stall): exactly one result beat per input beat, in order,
// carrying any send, the enqueue status, a give-up flag and the status
// after that beat (link fault, failure count, queue fill).
// Configuration: cfg_we writes cfg_data into the register selected by
// cfg_index (gap ticks, ack timeout ticks, max tries, link disable); the
// user must write it only while no beat is in flight; it is not enforced.
// A beat's result is registered and appears on the output in the cycle
// after the beat is accepted. Throughput is one beat per cycle while the
// receiver does not stall; the whole state update is one pass of logic
// from the input beat into the state and result registers. The queue is a
// RAM with registered read, and its head entry is prefetched every cycle.
// When the receiver stalls, the result register holds its beat and
// in_stall is raised in the same cycle, so nothing is dropped.
// Reset (rst_n low, synchronous) empties the queue, returns the sender to
// idle, clears the fault and failure count and restores register defaults.
// No clearing pass runs; the queue is usable in the first cycle after reset.
module acked_command_sender
  import acs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = ACS_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [CODE_W-1:0]  in_code,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_send_valid,
  output logic [CODE_W-1:0]  out_send_code,
  output logic               out_enqueue_ok,
  output logic               out_give_up,
  output logic               out_link_fault,
  output logic [FAIL_W-1:0]  out_failure_count,
  output logic [QCNT_W-1:0]  out_queued,
  // Configuration port
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [TICK_W-1:0]  cfg_data
);

  `include "acked_command_sender_assert.svh"

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = ((PTR_W > QCNT_W) ? PTR_W : QCNT_W) + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(QUEUE_DEPTH);
  localparam logic [TRIES_W-1:0] TRIES_MAX = '1;
  localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ARM   = 3'd1,
    PH_GAP   = 3'd2,
    PH_WAIT  = 3'd3,
    PH_RETRY = 3'd4
  } phase_t;

  // Configuration registers
  logic [TICK_W-1:0]  gap_ticks_r;
  logic [TICK_W-1:0]  ack_timeout_r;
  logic [TRIES_W-1:0] max_tries_r;
  logic               link_disabled_r;

  // Sender state
  phase_t             phase_r, phase_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [CODE_W-1:0]  cur_code_r, cur_code_nxt;
  logic [TRIES_W-1:0] tries_r, tries_nxt;
  logic [TICK_W-1:0]  wait_cnt_r, wait_cnt_nxt;
  logic               ack_seen_r, ack_seen_nxt;
  logic               fault_r, fault_nxt;
  logic [FAIL_W-1:0]  failures_r, failures_nxt;

  // Head prefetch and write bypass
  logic               byp_r, byp_nxt;
  logic [CODE_W-1:0]  byp_code_r;
  logic [CODE_W-1:0]  ram_rdata;
  logic [CODE_W-1:0]  head_code;
  logic               ram_we;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic               out_send_valid_r;
  logic [CODE_W-1:0]  out_send_code_r;
  logic               out_enqueue_ok_r;
  logic               out_give_up_r;
  logic               out_link_fault_r;
  logic [FAIL_W-1:0]  out_failure_count_r;
  logic [QCNT_W-1:0]  out_queued_r;

  // Per-beat results
  logic               send_nxt;
  logic               enq_ok_nxt;
  logic               give_up_nxt;
  logic [CNT_W-1:0]   count_nxt;

  logic               in_acc;
  logic [PTR_W-1:0]   wr_ptr_inc;
  logic [PTR_W-1:0]   rd_ptr_inc;
  logic               q_full;
  logic               q_empty;
  logic [TICK_W-1:0]  wait_dec;
  logic [TRIES_W-1:0] tries_inc;

  // Handshake: a result waiting on a stalled receiver blocks the input.
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // Queue pointers and status.
  assign wr_ptr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign q_full     = (wr_ptr_inc == rd_ptr_r);
  assign q_empty    = (wr_ptr_r == rd_ptr_r);
  assign head_code  = byp_r ? byp_code_r : ram_rdata;
  assign wait_dec   = (wait_cnt_r != '0) ? wait_cnt_r - 1'b1 : '0;
  assign tries_inc  = (tries_r != TRIES_MAX) ? tries_r + 1'b1 : tries_r;

  // Next state for one accepted beat.
  always_comb begin
    phase_nxt    = phase_r;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    cur_code_nxt = cur_code_r;
    tries_nxt    = tries_r;
    wait_cnt_nxt = wait_cnt_r;
    ack_seen_nxt = ack_seen_r;
    fault_nxt    = fault_r;
    failures_nxt = failures_r;
    ram_we       = 1'b0;
    send_nxt     = 1'b0;
    enq_ok_nxt   = 1'b0;
    give_up_nxt  = 1'b0;
    if (in_acc) begin
      case (in_mode)
        MODE_ENQUEUE: begin
          if (!q_full) begin
            ram_we     = 1'b1;
            wr_ptr_nxt = wr_ptr_inc;
            enq_ok_nxt = 1'b1;
          end
        end
        MODE_ACK: begin
          if (phase_r == PH_WAIT && in_code == cur_code_r) begin
            ack_seen_nxt = 1'b1;
          end
        end
        MODE_TICK: begin
          case (phase_r)
            PH_ARM: begin
              wait_cnt_nxt = gap_ticks_r;
              phase_nxt    = PH_GAP;
            end
            PH_GAP: begin
              wait_cnt_nxt = wait_dec;
              if (wait_dec == '0) begin
                send_nxt     = 1'b1;
                wait_cnt_nxt = ack_timeout_r;
                ack_seen_nxt = 1'b0;
                phase_nxt    = PH_WAIT;
              end
            end
            PH_WAIT: begin
              if (ack_seen_r) begin
                ack_seen_nxt = 1'b0;
                fault_nxt    = 1'b0;
                phase_nxt    = PH_IDLE;
              end else begin
                wait_cnt_nxt = wait_dec;
                if (wait_dec == '0) begin
                  phase_nxt = PH_RETRY;
                end
              end
            end
            PH_RETRY: begin
              tries_nxt = tries_inc;
              if (tries_inc >= max_tries_r) begin
                give_up_nxt = 1'b1;
                fault_nxt   = 1'b1;
                if (failures_r != FAIL_MAX) begin
                  failures_nxt = failures_r + 1'b1;
                end
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_ARM;
              end
            end
            default: begin
              // Idle, and any unused phase, takes the next queued code unless disabled.
              phase_nxt = PH_IDLE;
              if (!link_disabled_r && !q_empty) begin
                cur_code_nxt = head_code;
                rd_ptr_nxt   = rd_ptr_inc;
                tries_nxt    = '0;
                phase_nxt    = PH_ARM;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // Fill level after this beat.
  always_comb begin
    if (wr_ptr_nxt >= rd_ptr_nxt) begin
      count_nxt = CNT_W'(wr_ptr_nxt) - CNT_W'(rd_ptr_nxt);
    end else begin
      count_nxt = CNT_W'(wr_ptr_nxt) + CNT_DEPTH - CNT_W'(rd_ptr_nxt);
    end
  end

  // A write to the entry that is read next is forwarded past the RAM.
  assign byp_nxt       = ram_we && (wr_ptr_r == rd_ptr_nxt);
  assign out_valid_nxt = in_acc | (out_valid_r & out_stall);

  // Command queue storage; always reading the entry at the next head.
  acs_ram #(
    .WIDTH (CODE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (in_code),
    .raddr (rd_ptr_nxt),
    .rdata (ram_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_ticks_r     <= GAP_TICKS_RST;
      ack_timeout_r   <= ACK_TIMEOUT_RST;
      max_tries_r     <= MAX_TRIES_RST;
      link_disabled_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAP_TICKS:     gap_ticks_r     <= cfg_data;
        CFG_ACK_TIMEOUT:   ack_timeout_r   <= cfg_data;
        CFG_MAX_TRIES:     max_tries_r     <= cfg_data[TRIES_W-1:0];
        CFG_LINK_DISABLED: link_disabled_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sender state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      cur_code_r  <= '0;
      tries_r     <= '0;
      wait_cnt_r  <= '0;
      ack_seen_r  <= 1'b0;
      fault_r     <= 1'b0;
      failures_r  <= '0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      cur_code_r  <= cur_code_nxt;
      tries_r     <= tries_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
      ack_seen_r  <= ack_seen_nxt;
      fault_r     <= fault_nxt;
      failures_r  <= failures_nxt;
      byp_r       <= byp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    byp_code_r <= in_code;
    if (in_acc) begin
      out_send_valid_r    <= send_nxt;
      out_send_code_r     <= send_nxt ? cur_code_r : '0;
      out_enqueue_ok_r    <= enq_ok_nxt;
      out_give_up_r       <= give_up_nxt;
      out_link_fault_r    <= fault_nxt;
      out_failure_count_r <= failures_nxt;
      out_queued_r        <= count_nxt[QCNT_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_send_valid    = out_send_valid_r;
  assign out_send_code     = out_send_code_r;
  assign out_enqueue_ok    = out_enqueue_ok_r;
  assign out_give_up       = out_give_up_r;
  assign out_link_fault    = out_link_fault_r;
  assign out_failure_count = out_failure_count_r;
  assign out_queued        = out_queued_r;

  // A give-up beat always reports the fault it raises.
  `ACS_ASSERT_NOW(give_up_faults_a, out_valid_r && out_give_up_r, out_link_fault_r)
  // A send beat leaves the sender waiting for its acknowledgement.
  `ACS_ASSERT_NEXT(send_then_wait_a, in_acc && send_nxt, phase_r == PH_WAIT)
  // The failure count never goes down outside reset.
  `ACS_ASSERT_NEXT(failures_mono_a, 1'b1, failures_r >= $past(failures_r))
  // Codes are only taken from a non-empty queue.
  `ACS_ASSERT_NOW(take_nonempty_a, rd_ptr_nxt != rd_ptr_r, !q_empty)

endmodule

// ===== hw/rtl/acs_ram.sv =====
module acs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port; a read of the address being written
  // returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import acs_pkg::*;

  localparam int unsigned QDEPTH = ACS_QUEUE_DEPTH;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned MAX_LOGGED = 10;

  // The input mode that the block does not define.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Receiver stall patterns.
  localparam int unsigned RX_FREE = 0;
  localparam int unsigned RX_LIGHT = 1;
  localparam int unsigned RX_HEAVY = 2;
  localparam int unsigned RX_PERIODIC = 3;

  // Phases of the sender as tracked by the predictor.
  typedef enum logic [2:0] {
    SND_IDLE  = 3'd0,
    SND_ARM   = 3'd1,
    SND_GAP   = 3'd2,
    SND_AWAIT = 3'd3,
    SND_RETRY = 3'd4
  } snd_phase_t;

  // One result beat, in port order.
  typedef struct packed {
    logic              send_valid;
    logic [CODE_W-1:0] send_code;
    logic              enqueue_ok;
    logic              give_up;
    logic              link_fault;
    logic [FAIL_W-1:0] failure_count;
    logic [QCNT_W-1:0] queued;
  } report_t;

  // One row of the directed script: a beat or a register write.
  typedef struct {
    bit                is_reg;
    logic [CIDX_W-1:0] reg_idx;
    logic [1:0]        mode;
    logic [TICK_W-1:0] value;
    bit                typed;
    report_t           want;
  } script_row_t;

  // Register settings and stimulus shape of one random run.
  typedef struct {
    logic [TICK_W-1:0]  gap;
    logic [TICK_W-1:0]  timeout;
    logic [TRIES_W-1:0] tries;
    logic               disabled;
    int unsigned        beats;
    int unsigned        ack_pct;
    bit                 hold;
  } run_plan_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_mode;
  logic [CODE_W-1:0]  in_code;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_send_valid;
  logic [CODE_W-1:0]  out_send_code;
  logic               out_enqueue_ok;
  logic               out_give_up;
  logic               out_link_fault;
  logic [FAIL_W-1:0]  out_failure_count;
  logic [QCNT_W-1:0]  out_queued;
  logic               cfg_we;
  logic [CIDX_W-1:0]  cfg_index;
  logic [TICK_W-1:0]  cfg_data;

  acked_command_sender #(
    .QUEUE_DEPTH(QDEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_code          (in_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_send_valid   (out_send_valid),
    .out_send_code    (out_send_code),
    .out_enqueue_ok   (out_enqueue_ok),
    .out_give_up      (out_give_up),
    .out_link_fault   (out_link_fault),
    .out_failure_count(out_failure_count),
    .out_queued       (out_queued),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Clock with a period of 12.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted copy of the sender: registers, queue and phase machine.
  logic [TICK_W-1:0]  reg_gap;
  logic [TICK_W-1:0]  reg_timeout;
  logic [TRIES_W-1:0] reg_tries;
  logic               reg_disabled;
  logic [CODE_W-1:0]  cmd_store [QDEPTH];
  int unsigned        rd_ptr;
  int unsigned        wr_ptr;
  snd_phase_t         snd_phase;
  logic [CODE_W-1:0]  cur_code;
  logic [TRIES_W-1:0] tries_count;
  logic [TICK_W-1:0]  tick_count;
  logic               ack_pending;
  logic               fault_latched;
  logic [FAIL_W-1:0]  give_up_total;

  // Expected result beats, oldest first.
  report_t expected_reports [$];

  // Run bookkeeping.
  int unsigned check_errors;
  int unsigned logged_errors;
  int unsigned beats_done;
  int unsigned sends_done;
  int unsigned acked_done;
  int unsigned give_ups_done;
  int unsigned rejects_done;
  int unsigned cycle_count;
  int unsigned hold_requests;
  int unsigned burst_left;
  bit          cfg_held;

  script_row_t script [$];
  run_plan_t   plans [8] = '{
    '{GAP_TICKS_RST, ACK_TIMEOUT_RST, MAX_TRIES_RST, 1'b0, 300, 90, 1'b0},
    '{16'd0,  16'd0,  4'd1,  1'b0, 250, 30, 1'b0},
    '{16'd3,  16'd8,  4'd4,  1'b0, 300, 50, 1'b0},
    '{16'd1,  16'd2,  4'd15, 1'b0, 250, 5,  1'b0},
    '{16'd0,  16'd5,  4'd0,  1'b0, 200, 40, 1'b0},
    '{16'd2,  16'd4,  4'd2,  1'b1, 150, 50, 1'b0},
    '{16'd5,  16'd20, 4'd3,  1'b0, 250, 60, 1'b1},
    '{16'd0,  16'd3,  4'd2,  1'b0, 100, 70, 1'b0}
  };

  function automatic report_t make_report(logic sv, logic [CODE_W-1:0] sc, logic eo,
                                          logic gu, logic lf, logic [FAIL_W-1:0] fc,
                                          logic [QCNT_W-1:0] q);
    report_t r;
    r = '{sv, sc, eo, gu, lf, fc, q};
    return r;
  endfunction

  function automatic string describe(report_t r);
    return $sformatf("send=%0b code=%h enq=%0b give_up=%0b fault=%0b fails=%0d queued=%0d",
                     r.send_valid, r.send_code, r.enqueue_ok, r.give_up, r.link_fault,
                     r.failure_count, r.queued);
  endfunction

  // Advances the predicted sender by one beat and returns its result.
  function automatic report_t predict_sender_beat(logic [1:0] mode, logic [CODE_W-1:0] code);
    report_t     r;
    int unsigned nxt;
    r = '0;
    case (mode)
      MODE_ENQUEUE: begin
        nxt = (wr_ptr + 1) % QDEPTH;
        if (nxt != rd_ptr) begin
          cmd_store[wr_ptr] = code;
          wr_ptr = nxt;
          r.enqueue_ok = 1'b1;
        end
      end
      MODE_ACK: begin
        if (snd_phase == SND_AWAIT && code == cur_code) ack_pending = 1'b1;
      end
      MODE_TICK: begin
        case (snd_phase)
          SND_ARM: begin
            tick_count = reg_gap;
            snd_phase = SND_GAP;
          end
          SND_GAP: begin
            if (tick_count != 0) tick_count--;
            if (tick_count == 0) begin
              r.send_valid = 1'b1;
              r.send_code = cur_code;
              tick_count = reg_timeout;
              ack_pending = 1'b0;
              snd_phase = SND_AWAIT;
            end
          end
          SND_AWAIT: begin
            if (ack_pending) begin
              ack_pending = 1'b0;
              fault_latched = 1'b0;
              snd_phase = SND_IDLE;
              acked_done++;
            end else begin
              if (tick_count != 0) tick_count--;
              if (tick_count == 0) snd_phase = SND_RETRY;
            end
          end
          SND_RETRY: begin
            if (tries_count != 4'd15) tries_count++;
            if (tries_count >= reg_tries) begin
              r.give_up = 1'b1;
              fault_latched = 1'b1;
              if (give_up_total != 16'hFFFF) give_up_total++;
              snd_phase = SND_IDLE;
            end else begin
              snd_phase = SND_ARM;
            end
          end
          default: begin
            snd_phase = SND_IDLE;
            if (!reg_disabled && rd_ptr != wr_ptr) begin
              cur_code = cmd_store[rd_ptr];
              rd_ptr = (rd_ptr + 1) % QDEPTH;
              tries_count = '0;
              snd_phase = SND_ARM;
            end
          end
        endcase
      end
      default: ;
    endcase
    r.link_fault = fault_latched;
    r.failure_count = give_up_total;
    r.queued = QCNT_W'((QDEPTH + wr_ptr - rd_ptr) % QDEPTH);
    return r;
  endfunction

  // Offers one beat, waits for it to be taken and records what it should produce.
  // Between bursts the sender may hold valid low before the next beat.
  task automatic issue_beat(input logic [1:0] mode, input logic [CODE_W-1:0] code,
                            input bit typed = 1'b0, input report_t want = '0);
    report_t     predicted;
    int unsigned gap;
    if (cfg_held) begin
      cfg_we <= 1'b0;
      cfg_held = 1'b0;
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_code <= code;
    do @(posedge clk); while (in_stall);
    predicted = predict_sender_beat(mode, code);
    beats_done++;
    if (predicted.send_valid) sends_done++;
    if (predicted.give_up) give_ups_done++;
    if (mode == MODE_ENQUEUE && !predicted.enqueue_ok) rejects_done++;
    expected_reports.push_back(typed ? want : predicted);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(60, 200) : $urandom_range(1, 30);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering beats and waits until every expected result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // Writes one register; the write enable stays high until the next beat.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [TICK_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_GAP_TICKS:   reg_gap = value;
      CFG_ACK_TIMEOUT: reg_timeout = value;
      CFG_MAX_TRIES:   reg_tries = value[TRIES_W-1:0];
      default:         reg_disabled = value[0];
    endcase
    cfg_held = 1'b1;
  endtask

  // Writes all four registers once the block has gone quiet.
  // Unused upper data bits carry noise for the narrow registers.
  task automatic write_all_regs(input logic [TICK_W-1:0] gap, input logic [TICK_W-1:0] timeout,
                                input logic [TRIES_W-1:0] tries, input logic disabled);
    if (!cfg_held) wait_for_results();
    write_reg(CFG_GAP_TICKS, gap);
    write_reg(CFG_ACK_TIMEOUT, timeout);
    write_reg(CFG_MAX_TRIES, {12'($urandom), tries});
    write_reg(CFG_LINK_DISABLED, {15'($urandom), disabled});
  endtask

  // One random beat. While a send waits for its acknowledgement the matching
  // code is offered with the given chance; otherwise mostly ticks and enqueues,
  // with some stray acknowledgements and beats of the unused mode.
  task automatic random_beat(input int unsigned ack_pct);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (snd_phase == SND_AWAIT && pick < ack_pct) begin
      issue_beat(MODE_ACK, cur_code);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 4) issue_beat(MODE_UNUSED, CODE_W'($urandom));
      else if (pick < 9) issue_beat(MODE_ACK, CODE_W'($urandom));
      else if (pick < 34) issue_beat(MODE_ENQUEUE, CODE_W'($urandom));
      else issue_beat(MODE_TICK, CODE_W'($urandom));
    end
  endtask

  task automatic run_plan(input run_plan_t plan);
    write_all_regs(plan.gap, plan.timeout, plan.tries, plan.disabled);
    for (int unsigned i = 0; i < plan.beats; i++) begin
      if (plan.hold && i == 100) hold_requests++;
      random_beat(plan.ack_pct);
    end
  endtask

  // Result checker: every taken result beat is compared with the oldest expectation.
  report_t seen_report;
  report_t want_report;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_report = {out_send_valid, out_send_code, out_enqueue_ok, out_give_up,
                     out_link_fault, out_failure_count, out_queued};
      if (expected_reports.size() == 0) begin
        check_errors++;
        if (logged_errors < MAX_LOGGED) begin
          logged_errors++;
          $display("%0t: result beat with nothing expected: %s", $time, describe(seen_report));
        end
      end else begin
        want_report = expected_reports.pop_front();
        if (seen_report.send_valid !== want_report.send_valid ||
            seen_report.send_code !== want_report.send_code ||
            seen_report.enqueue_ok !== want_report.enqueue_ok ||
            seen_report.give_up !== want_report.give_up ||
            seen_report.link_fault !== want_report.link_fault ||
            seen_report.failure_count !== want_report.failure_count ||
            seen_report.queued !== want_report.queued) begin
          check_errors++;
          if (logged_errors < MAX_LOGGED) begin
            logged_errors++;
            $display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
                     describe(want_report), describe(seen_report));
          end
        end
      end
    end
  end

  // Receiver stall: a randomly chosen pattern, redrawn when its random span runs out,
  // plus one long hold when asked, so that the block fills and stalls its input.
  int unsigned rx_hold_left;
  int unsigned rx_holds_done;
  int unsigned rx_pattern;
  int unsigned rx_pattern_left;
  int unsigned rx_tick;
  always @(posedge clk) begin
    rx_tick++;
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else if (rx_holds_done != hold_requests) begin
      rx_holds_done++;
      rx_hold_left = LONG_HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (rx_pattern_left == 0) begin
        rx_pattern = $urandom_range(RX_FREE, RX_PERIODIC);
        rx_pattern_left = $urandom_range(16, 400);
      end
      rx_pattern_left--;
      case (rx_pattern)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= $urandom_range(0, 99) < 20;
        RX_HEAVY: out_stall <= $urandom_range(0, 99) < 70;
        default:  out_stall <= (rx_tick % 8) < 3;
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Directed script: reset status, a full queue, a rejected enqueue, a zero
  // try limit with zero gap and timeout, an acknowledgement for another code,
  // the link disabled while a command runs, and an enqueue while disabled.
  initial begin
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_TICK, 16'h0000, 1'b1,
                       make_report(0, 16'h0, 0, 0, 0, 0, 0)});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_UNUSED, 16'hFFFF, 1'b1,
                       make_report(0, 16'h0, 0, 0, 0, 0, 0)});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_ACK, 16'h0000, 1'b1,
                       make_report(0, 16'h0, 0, 0, 0, 0, 0)});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_ENQUEUE, 16'h0000, 1'b1,
                       make_report(0, 16'h0, 1, 0, 0, 0, 1)});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_ENQUEUE, 16'hFFFF, 1'b1,
                       make_report(0, 16'h0, 1, 0, 0, 0, 2)});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_ENQUEUE, 16'h5555, 1'b1,
                       make_report(0, 16'h0, 1, 0, 0, 0, 3)});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_ENQUEUE, 16'hAAAA, 1'b1,
                       make_report(0, 16'h0, 1, 0, 0, 0, 4)});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_ENQUEUE, 16'h1234, 1'b1,
                       make_report(0, 16'h0, 1, 0, 0, 0, 5)});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_ENQUEUE, 16'h8001, 1'b1,
                       make_report(0, 16'h0, 1, 0, 0, 0, 6)});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_ENQUEUE, 16'h7FFE, 1'b1,
                       make_report(0, 16'h0, 1, 0, 0, 0, 7)});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_ENQUEUE, 16'hBEEF, 1'b1,
                       make_report(0, 16'h0, 0, 0, 0, 0, 7)});
    script.push_back('{1'b1, CFG_GAP_TICKS, MODE_TICK, 16'd0, 1'b0, '0});
    script.push_back('{1'b1, CFG_ACK_TIMEOUT, MODE_TICK, 16'd0, 1'b0, '0});
    script.push_back('{1'b1, CFG_MAX_TRIES, MODE_TICK, 16'd0, 1'b0, '0});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_TICK, 16'h0000, 1'b1,
                       make_report(0, 16'h0, 0, 0, 0, 0, 6)});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_TICK, 16'h0000, 1'b0, '0});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_TICK, 16'h0000, 1'b1,
                       make_report(1, 16'h0000, 0, 0, 0, 0, 6)});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_ACK, 16'hFFFF, 1'b0, '0});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_TICK, 16'h0000, 1'b0, '0});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_TICK, 16'h0000, 1'b1,
                       make_report(0, 16'h0, 0, 1, 1, 1, 6)});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_TICK, 16'h0000, 1'b0, '0});
    script.push_back('{1'b1, CFG_LINK_DISABLED, MODE_TICK, 16'd1, 1'b0, '0});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_TICK, 16'h0000, 1'b0, '0});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_TICK, 16'h0000, 1'b1,
                       make_report(1, 16'hFFFF, 0, 0, 1, 1, 5)});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_ACK, 16'hFFFF, 1'b0, '0});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_TICK, 16'h0000, 1'b1,
                       make_report(0, 16'h0, 0, 0, 0, 1, 5)});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_TICK, 16'h0000, 1'b0, '0});
    script.push_back('{1'b0, CFG_GAP_TICKS, MODE_ENQUEUE, 16'h0001, 1'b1,
                       make_report(0, 16'h0, 1, 0, 0, 1, 6)});
  end

  // Main sequence.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_TICK;
    in_code = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_GAP_TICKS;
    cfg_data = '0;

    // Predictor after reset.
    reg_gap = GAP_TICKS_RST;
    reg_timeout = ACK_TIMEOUT_RST;
    reg_tries = MAX_TRIES_RST;
    reg_disabled = 1'b0;
    rd_ptr = 0;
    wr_ptr = 0;
    snd_phase = SND_IDLE;
    cur_code = '0;
    tries_count = '0;
    tick_count = '0;
    ack_pending = 1'b0;
    fault_latched = 1'b0;
    give_up_total = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        if (!cfg_held) wait_for_results();
        write_reg(script[i].reg_idx, script[i].value);
      end else begin
        issue_beat(script[i].mode, script[i].value, script[i].typed, script[i].want);
      end
    end

    for (int p = 0; p < 7; p++) run_plan(plans[p]);

    // A short closing run where most sends are acknowledged and clear the fault.
    run_plan(plans[7]);

    if (cfg_held) cfg_we <= 1'b0;
    wait_for_results();
    repeat (4) @(posedge clk);
    check_errors += expected_reports.size();

    $display("Ran %0d beats: %0d sends, %0d acknowledged, %0d give-ups, %0d enqueues rejected.",
             beats_done, sends_done, acked_done, give_ups_done, rejects_done);
    $display("Failure count reached %0d; %0d result errors.", give_up_total, check_errors);
    if (check_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
